// ----- src/magnetometer_baseline_tracker_top_defines.svh -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_BASELINE_TRACKER_TOP_DEFINES_SVH
`define MAGNETOMETER_BASELINE_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbt check failed");

// next-cycle implication, disabled in reset
`define MBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbt check failed");

`endif

// ----- src/mbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker package
// Widths, codes, constants and the job record shared by all blocks but the square root.
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

    localparam int AXIS_W       = 13;
    localparam int MAG_W        = 17;
    localparam int SPEED_W      = 17;
    localparam int SPEED_FRAC_W = 16;
    localparam int THR_W        = 17;
    localparam int COUNT_W      = 4;
    localparam int BASE_W       = MAG_W + SPEED_FRAC_W;
    localparam int SQ_W         = 26;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;

    localparam int DEF_MAX_SENSORS   = 8;
    localparam int DEF_MAG_FRAC_BITS = 4;
    localparam int MIN_SENSORS       = 3;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [COUNT_W-1:0] RST_SENSOR_COUNT = 4'd3;
    localparam logic [SPEED_W-1:0] ONE_SPEED        = 17'h10000;
    localparam logic [THR_W-1:0]   RST_THRESHOLD    = 17'd0;

    localparam logic signed [AXIS_W-1:0] SAT_LIMIT = 13'sd4090;
    localparam logic signed [AXIS_W-1:0] SAT_NEG   = -13'sd4090;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_SPEED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_CALIB   = 1'b1;

    typedef struct packed {
        logic                     calib;
        logic                     sat;
        logic                     last;
        logic                     frame_ok;
        logic                     bank;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
    } t_job;

endpackage

`default_nettype wire

// ----- src/mbt_channels.sv -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker channels
// Valid/ready interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbt_in_if import mbt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;

    modport source(output valid, action, axis_x, axis_y, axis_z, input ready);
    modport sink(input valid, action, axis_x, axis_y, axis_z, output ready);
endinterface

interface mbt_out_if import mbt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic [MAG_W-1:0] deviation;
    logic             axis_saturated;
    logic             last_of_frame;
    logic             frame_valid;
    logic             source_present;

    modport source(output valid, magnitude, deviation, axis_saturated, last_of_frame,
                   frame_valid, source_present, input ready);
    modport sink(input valid, magnitude, deviation, axis_saturated, last_of_frame,
                 frame_valid, source_present, output ready);
endinterface

interface mbt_cfg_if import mbt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/mbt_front.sv -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker front end
// Accepts samples, tracks frame position, saturation and the active bank.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_front import mbt_pkg::*; #(
    parameter int MAX_SENSORS = DEF_MAX_SENSORS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mbt_in_if.sink                         i_in,
    input  logic [COUNT_W-1:0]             i_sensor_count,
    output logic                           o_push_valid,
    input  logic                           i_push_ready,
    output t_job                           o_job,
    output logic [$clog2(MAX_SENSORS)-1:0] o_pos
);

    localparam int POS_W = $clog2(MAX_SENSORS);
    localparam int CNT_W = $clog2(MAX_SENSORS + 1);
    localparam int CMP_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_frame_sat, n_frame_sat;
    logic             r_bank, n_bank;
    logic [CMP_W-1:0] cnt_cfg, cnt_eff, pos_inc;
    logic             sat, last, frame_ok, calib, accept;

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;
    assign accept       = i_in.valid && i_push_ready;

    always_comb begin
        cnt_cfg = CMP_W'(i_sensor_count);
        if (cnt_cfg < CMP_W'(MIN_SENSORS)) begin
            cnt_eff = CMP_W'(MIN_SENSORS);
        end else if (cnt_cfg > CMP_W'(MAX_SENSORS)) begin
            cnt_eff = CMP_W'(MAX_SENSORS);
        end else begin
            cnt_eff = cnt_cfg;
        end
        pos_inc  = CMP_W'(r_pos) + CMP_W'(1);
        last     = (pos_inc >= cnt_eff);
        sat      = (i_in.axis_x > SAT_LIMIT) || (i_in.axis_x < SAT_NEG) ||
                   (i_in.axis_y > SAT_LIMIT) || (i_in.axis_y < SAT_NEG) ||
                   (i_in.axis_z > SAT_LIMIT) || (i_in.axis_z < SAT_NEG);
        frame_ok = !(r_frame_sat || sat);
        calib    = (i_in.action == ACT_CALIB);
    end

    always_comb begin
        o_job.calib    = calib;
        o_job.sat      = sat;
        o_job.last     = last;
        o_job.frame_ok = frame_ok;
        o_job.bank     = r_bank;
        o_job.axis_x   = i_in.axis_x;
        o_job.axis_y   = i_in.axis_y;
        o_job.axis_z   = i_in.axis_z;
        o_pos          = r_pos;
    end

    always_comb begin
        n_pos       = r_pos;
        n_frame_sat = r_frame_sat;
        n_bank      = r_bank;
        if (accept) begin
            if (last) begin
                n_pos       = '0;
                n_frame_sat = 1'b0;
                n_bank      = (frame_ok && calib) ? ~r_bank : r_bank;
            end else begin
                n_pos       = POS_W'(pos_inc);
                n_frame_sat = r_frame_sat || sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_frame_sat <= 1'b0;
            r_bank      <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_frame_sat <= n_frame_sat;
            r_bank      <= n_bank;
        end
    end

endmodule

`default_nettype wire

// ----- src/mbt_queue.sv -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker job queue
// Short first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_queue import mbt_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  logic [W-1:0] i_push_data,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output logic [W-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_store [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_store[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_store[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/mbt_sqrt.sv -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker square root
// Bit-serial integer square root, one root bit per cycle, floored.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_sqrt #(
    parameter int RAD_W = 34
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [RAD_W-1:0]     i_radicand,
    output logic                 o_done,
    output logic [RAD_W/2-1:0]   o_root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int TRY_W  = REM_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic              r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [TRY_W-1:0]  rem_sh, sub, trial;
    logic              fits;

    assign o_done = r_done;
    assign o_root = r_root;

    always_comb begin
        rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        sub    = {2'b00, r_root, 2'b01};
        fits   = (rem_sh >= sub);
        trial  = rem_sh - sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W - 1);
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad <= r_rad << 2;
                if (fits) begin
                    r_rem  <= trial[REM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[REM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/mbt_back.sv -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker back end
// Magnitude, deviation, baseline averaging into a double bank, frame flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_back import mbt_pkg::*; #(
    parameter int MAX_SENSORS   = DEF_MAX_SENSORS,
    parameter int MAG_FRAC_BITS = DEF_MAG_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_pop_valid,
    output logic                           o_pop_ready,
    input  t_job                           i_job,
    input  logic [$clog2(MAX_SENSORS)-1:0] i_pos,
    input  logic [SPEED_W-1:0]             i_ema_speed,
    input  logic [THR_W-1:0]               i_presence_threshold,
    mbt_out_if.source                      o_out
);

    localparam int POS_W   = $clog2(MAX_SENSORS);
    localparam int ADDR_W  = POS_W + 1;
    localparam int ENTRIES = 2 ** ADDR_W;
    localparam int PX_W    = 2 * AXIS_W;
    localparam int SQ1_W   = 2 * AXIS_W - 1;
    localparam int RAD_W   = SQ_W + 2 * MAG_FRAC_BITS;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int DIFF_W  = BASE_W + 1;
    localparam int SPD_W   = SPEED_W + 1;
    localparam int PROD_W  = DIFF_W + SPD_W;
    localparam int STEP_W  = PROD_W - SPEED_FRAC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_ROOT,
        S_DIFF,
        S_MUL,
        S_UPD
    } t_state;

    t_state                    r_state;
    t_job                      r_job;
    logic [POS_W-1:0]          r_pos;
    logic [SQ1_W-1:0]          r_sq_x, r_sq_y, r_sq_z;
    logic [MAG_W-1:0]          r_mag;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_all_above;

    logic                      r_out_valid;
    logic [MAG_W-1:0]          r_out_mag, r_out_dev;
    logic                      r_out_sat, r_out_last, r_out_ok, r_out_present;

    logic [BASE_W-1:0]         r_mem [ENTRIES];
    logic [ENTRIES-1:0]        r_vld;
    logic [BASE_W-1:0]         r_rd_data;
    logic                      r_rd_vld;

    logic signed [PX_W-1:0]    px, py, pz;
    logic [SQ_W-1:0]           sq_sum;
    logic [RAD_W-1:0]          radicand;
    logic                      root_done;
    logic [ROOT_W-1:0]         root;
    logic [ROOT_W+MAG_W-1:0]   root_ext;
    logic [BASE_W-1:0]         base, big, next_base;
    logic signed [DIFF_W-1:0]  diff_w, dev_abs;
    logic [MAG_W-1:0]          dev;
    logic                      below, speed_ok, out_free, wr_en;
    logic [SPEED_W-1:0]        s_eff;
    logic signed [STEP_W-1:0]  step, next_sum;
    logic [ADDR_W-1:0]         rd_addr, wr_addr;

    mbt_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SUM),
        .i_radicand (radicand),
        .o_done     (root_done),
        .o_root     (root)
    );

    always_comb begin
        px       = PX_W'(i_job.axis_x) * PX_W'(i_job.axis_x);
        py       = PX_W'(i_job.axis_y) * PX_W'(i_job.axis_y);
        pz       = PX_W'(i_job.axis_z) * PX_W'(i_job.axis_z);
        sq_sum   = SQ_W'(r_sq_x) + SQ_W'(r_sq_y) + SQ_W'(r_sq_z);
        radicand = RAD_W'(sq_sum) << (2 * MAG_FRAC_BITS);
        root_ext = {{MAG_W{1'b0}}, root};
        base     = r_rd_vld ? r_rd_data : '0;
        big      = {r_mag, {SPEED_FRAC_W{1'b0}}};
        diff_w   = $signed({1'b0, big}) - $signed({1'b0, base});
        dev_abs  = r_diff[DIFF_W-1] ? -r_diff : r_diff;
        dev      = dev_abs[BASE_W-1:SPEED_FRAC_W];
        below    = (dev < i_presence_threshold);
        speed_ok = (i_ema_speed != '0) && (i_ema_speed <= ONE_SPEED);
        s_eff    = (r_job.calib && speed_ok) ? i_ema_speed : '0;
        step     = r_prod[PROD_W-1:SPEED_FRAC_W];
        next_sum = $signed(STEP_W'(base)) + step;
        next_base = next_sum[BASE_W-1:0];
        out_free = !r_out_valid || o_out.ready;
        wr_en    = (r_state == S_UPD) && out_free;
        rd_addr  = {r_job.bank, r_pos};
        wr_addr  = {~r_job.bank, r_pos};
    end

    assign o_pop_ready          = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.magnitude      = r_out_mag;
    assign o_out.deviation      = r_out_dev;
    assign o_out.axis_saturated = r_out_sat;
    assign o_out.last_of_frame  = r_out_last;
    assign o_out.frame_valid    = r_out_ok;
    assign o_out.source_present = r_out_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_all_above <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && r_state != S_UPD) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_job   <= i_job;
                        r_pos   <= i_pos;
                        r_sq_x  <= px[SQ1_W-1:0];
                        r_sq_y  <= py[SQ1_W-1:0];
                        r_sq_z  <= pz[SQ1_W-1:0];
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (root_done) begin
                        r_mag   <= root_ext[MAG_W-1:0];
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_diff  <= diff_w;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_diff) * PROD_W'($signed({1'b0, s_eff}));
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_mag     <= r_mag;
                        r_out_dev     <= dev;
                        r_out_sat     <= r_job.sat;
                        r_out_last    <= r_job.last;
                        r_out_ok      <= r_job.last && r_job.frame_ok;
                        r_out_present <= r_job.last && r_job.frame_ok && !r_job.calib &&
                                         r_all_above && !below;
                        r_all_above   <= r_job.last ? 1'b1 : (r_all_above && !below);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= next_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- src/magnetometer_baseline_tracker_top.sv -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker top level
// The back end takes a new sample only once the current one is done; its
// bit-serial square root runs one root bit per cycle.
// Reset: synchronous, clears frame state, bank select and baseline valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_baseline_tracker_top import mbt_pkg::*; #(
    parameter int MAX_SENSORS   = DEF_MAX_SENSORS,
    parameter int MAG_FRAC_BITS = DEF_MAG_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbt_cfg_if.sink   i_cfg,
    mbt_in_if.sink    i_in,
    mbt_out_if.source o_out
);

    localparam int POS_W = $clog2(MAX_SENSORS);
    localparam int JOB_W = $bits(t_job);
    localparam int Q_W   = JOB_W + POS_W;

    logic [COUNT_W-1:0] r_sensor_count;
    logic [SPEED_W-1:0] r_ema_speed;
    logic [THR_W-1:0]   r_threshold;

    logic               push_valid, push_ready, pop_valid, pop_ready;
    t_job               front_job;
    logic [POS_W-1:0]   front_pos;
    logic [Q_W-1:0]     pop_data;
    t_job               pop_job;
    logic [POS_W-1:0]   pop_pos;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count <= RST_SENSOR_COUNT;
            r_ema_speed    <= ONE_SPEED;
            r_threshold    <= RST_THRESHOLD;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SENSOR_COUNT: r_sensor_count <= i_cfg.data[COUNT_W-1:0];
                CFG_EMA_SPEED:    r_ema_speed    <= i_cfg.data[SPEED_W-1:0];
                CFG_THRESHOLD:    r_threshold    <= i_cfg.data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    mbt_front #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_sensor_count (r_sensor_count),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_job          (front_job),
        .o_pos          (front_pos)
    );

    mbt_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  ({front_pos, front_job}),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    assign pop_job = t_job'(pop_data[JOB_W-1:0]);
    assign pop_pos = pop_data[Q_W-1 -: POS_W];

    mbt_back #(
        .MAX_SENSORS   (MAX_SENSORS),
        .MAG_FRAC_BITS (MAG_FRAC_BITS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_pop_valid          (pop_valid),
        .o_pop_ready          (pop_ready),
        .i_job                (pop_job),
        .i_pos                (pop_pos),
        .i_ema_speed          (r_ema_speed),
        .i_presence_threshold (r_threshold),
        .o_out                (o_out)
    );

endmodule

`default_nettype wire

// ----- src/mbt_checker.sv -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker checker
// Result channel checks on frame flags and stall behavior, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magnetometer_baseline_tracker_top_defines.svh"

module mbt_checker import mbt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [MAG_W-1:0] i_out_magnitude,
    input logic [MAG_W-1:0] i_out_deviation,
    input logic             i_out_sat,
    input logic             i_out_last,
    input logic             i_out_frame_valid,
    input logic             i_out_present
);

    `MBT_ASSERT_IMP(a_flags_only_at_last, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_out_frame_valid && !i_out_present)
    `MBT_ASSERT_IMP(a_present_needs_valid, i_clk, i_rst_n, i_out_valid && i_out_present, i_out_frame_valid)
    `MBT_ASSERT_IMP(a_sat_kills_frame, i_clk, i_rst_n, i_out_valid && i_out_last && i_out_sat, !i_out_frame_valid)
    `MBT_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_magnitude) && $stable(i_out_deviation))

endmodule

bind magnetometer_baseline_tracker_top mbt_checker u_mbt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_magnitude   (o_out.magnitude),
    .i_out_deviation   (o_out.deviation),
    .i_out_sat         (o_out.axis_saturated),
    .i_out_last        (o_out.last_of_frame),
    .i_out_frame_valid (o_out.frame_valid),
    .i_out_present     (o_out.source_present)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Magnetometer baseline tracker testbench
// Drives sensor frames (measure, calibrate, mixed, saturated, noisy) through
// the valid/ready sample channel, predicts every result with an internal
// copy of the baseline banks and frame state, and checks each result
// transaction field by field. Register writes happen between phases while
// the block is drained; both channel sides idle at random, and the result
// side holds off for long stretches to back the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import mbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 85;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                     action;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
    } sample_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [MAG_W-1:0] deviation;
        logic             axis_saturated;
        logic             last_of_frame;
        logic             frame_valid;
        logic             source_present;
    } reading_t;

    typedef enum {ACTS_MEASURE, ACTS_CALIB, ACTS_MIXED} action_plan_t;
    typedef enum {FRAME_QUIET, FRAME_SOURCE, FRAME_SATURATED, FRAME_NOISE} frame_kind_t;

    logic i_clk;
    logic i_rst_n;

    mbt_cfg_if cfg_ch();
    mbt_in_if  in_ch();
    mbt_out_if out_ch();

    magnetometer_baseline_tracker_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // tracker mirror: configuration, baseline banks and frame state
    logic [COUNT_W-1:0] cfg_count = RST_SENSOR_COUNT;
    logic [SPEED_W-1:0] cfg_speed = ONE_SPEED;
    logic [THR_W-1:0]   cfg_thr   = RST_THRESHOLD;
    logic [BASE_W-1:0]  baselines [2][DEF_MAX_SENSORS] = '{default: '0};
    logic               act_bank  = 1'b0;
    int unsigned        frame_pos = 0;
    logic               saw_sat   = 1'b0;
    logic               all_above = 1'b1;

    sample_t     samples_to_send[$];
    reading_t    expected_readings[$];
    sample_t     on_wire;
    reading_t    want;
    int          tx_wait    = 0;
    int          rx_wait    = 0;
    logic        tx_gaps_on = 1'b1;
    logic        rx_gaps_on = 1'b1;
    int          hold_reqs  = 0;
    int          hold_seen  = 0;
    int          mismatches = 0;
    int unsigned cycles     = 0;
    int          nom_x [DEF_MAX_SENSORS];
    int          nom_y [DEF_MAX_SENSORS];
    int          nom_z [DEF_MAX_SENSORS];

    function automatic int unsigned frame_len();
        if (cfg_count < MIN_SENSORS) return MIN_SENSORS;
        if (cfg_count > DEF_MAX_SENSORS) return DEF_MAX_SENSORS;
        return cfg_count;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] acc;
        logic [63:0] trial;
        int          b;
        acc = '0;
        for (b = 18; b >= 0; b--) begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= v) acc = trial;
        end
        return acc;
    endfunction

    function automatic reading_t track_sample(input sample_t s);
        reading_t    r;
        int unsigned n_eff;
        int unsigned slot;
        longint      ax;
        longint      ay;
        longint      az;
        logic [63:0] sq;
        logic [63:0] root_v;
        logic [63:0] base;
        logic [63:0] big;
        logic [63:0] dev;
        logic [63:0] nxt;
        logic        bank;
        n_eff = frame_len();
        slot  = frame_pos % DEF_MAX_SENSORS;
        ax = s.axis_x;
        ay = s.axis_y;
        az = s.axis_z;
        r.axis_saturated = s.axis_x > SAT_LIMIT || s.axis_x < SAT_NEG ||
                           s.axis_y > SAT_LIMIT || s.axis_y < SAT_NEG ||
                           s.axis_z > SAT_LIMIT || s.axis_z < SAT_NEG;
        sq = ax * ax + ay * ay + az * az;
        root_v = floor_root(sq << (2 * DEF_MAG_FRAC_BITS));
        r.magnitude = root_v[MAG_W-1:0];
        bank = act_bank;
        base = {31'b0, baselines[bank][slot]};
        big  = {47'b0, r.magnitude} << SPEED_FRAC_W;
        dev  = (big >= base) ? big - base : base - big;
        r.deviation = dev[SPEED_FRAC_W +: MAG_W];
        nxt = base;
        if (s.action == ACT_CALIB && cfg_speed != 0 && cfg_speed <= ONE_SPEED)
            nxt = (base * ({47'b0, ONE_SPEED} - cfg_speed) + big * cfg_speed) >> SPEED_FRAC_W;
        baselines[!bank][slot] = nxt[BASE_W-1:0];
        if (r.axis_saturated) saw_sat = 1'b1;
        if (r.deviation < cfg_thr) all_above = 1'b0;
        r.last_of_frame  = slot + 1 >= n_eff;
        r.frame_valid    = 1'b0;
        r.source_present = 1'b0;
        if (r.last_of_frame) begin
            r.frame_valid    = !saw_sat;
            r.source_present = r.frame_valid && s.action == ACT_MEASURE && all_above;
            if (r.frame_valid && s.action == ACT_CALIB) act_bank = !bank;
            frame_pos = 0;
            saw_sat   = 1'b0;
            all_above = 1'b1;
        end else begin
            frame_pos = slot + 1;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic logic signed [AXIS_W-1:0] near(input int v);
        int w;
        w = v + int'($urandom_range(0, 6)) - 3;
        if (w > 4090) w = 4090;
        if (w < -4090) w = -4090;
        return w[AXIS_W-1:0];
    endfunction

    task automatic push_sample(input logic act, input int x, input int y, input int z);
        sample_t s;
        s.action = act;
        s.axis_x = x[AXIS_W-1:0];
        s.axis_y = y[AXIS_W-1:0];
        s.axis_z = z[AXIS_W-1:0];
        samples_to_send = {samples_to_send, s};
    endtask

    task automatic add_frame(input int first, input int stop, input action_plan_t plan,
                             input frame_kind_t kind);
        sample_t                  s;
        int                       k;
        int                       hit;
        int                       offs;
        logic signed [AXIS_W-1:0] rail;
        hit  = $urandom_range(first, stop - 1);
        offs = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(150, 1500));
        for (k = first; k < stop; k++) begin
            case (plan)
                ACTS_MEASURE: s.action = ACT_MEASURE;
                ACTS_CALIB:   s.action = ACT_CALIB;
                default:      s.action = 1'($urandom_range(0, 1));
            endcase
            if (kind == FRAME_NOISE) begin
                s.axis_x = AXIS_W'($urandom);
                s.axis_y = AXIS_W'($urandom);
                s.axis_z = AXIS_W'($urandom);
            end else if (kind == FRAME_SOURCE) begin
                s.axis_x = near(nom_x[k] + offs);
                s.axis_y = near(nom_y[k] - offs);
                s.axis_z = near(nom_z[k] + offs / 2);
            end else begin
                s.axis_x = near(nom_x[k]);
                s.axis_y = near(nom_y[k]);
                s.axis_z = near(nom_z[k]);
            end
            if (kind == FRAME_SATURATED && k == hit) begin
                case ($urandom_range(0, 3))
                    0:       rail = 13'sd4091;
                    1:       rail = 13'sd4095;
                    2:       rail = -13'sd4091;
                    default: rail = -13'sd4096;
                endcase
                case ($urandom_range(0, 2))
                    0:       s.axis_x = rail;
                    1:       s.axis_y = rail;
                    default: s.axis_z = rail;
                endcase
            end
            samples_to_send = {samples_to_send, s};
        end
    endtask

    task automatic add_random_frame(input int first, input int stop);
        int           r;
        int           q;
        action_plan_t plan;
        frame_kind_t  kind;
        r = $urandom_range(0, 99);
        q = $urandom_range(0, 99);
        plan = (r < 45) ? ACTS_MEASURE : (r < 80) ? ACTS_CALIB : ACTS_MIXED;
        kind = (q < 55) ? FRAME_QUIET : (q < 80) ? FRAME_SOURCE :
               (q < 88) ? FRAME_SATURATED : FRAME_NOISE;
        add_frame(first, stop, plan, kind);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_SENSOR_COUNT: cfg_count = value[COUNT_W-1:0];
            CFG_EMA_SPEED:    cfg_speed = value[SPEED_W-1:0];
            CFG_THRESHOLD:    cfg_thr   = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (samples_to_send.size() != 0 || in_ch.valid || expected_readings.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // sample driver: hold until accepted, then idle or present the next one
    always @(posedge i_clk) begin
        if (i_rst_n && !(in_ch.valid && !in_ch.ready)) begin
            if (in_ch.valid) begin
                expected_readings = {expected_readings, track_sample(on_wire)};
                tx_wait = tx_gaps_on ? $urandom_range(0, 12) : 0;
            end
            if (tx_wait > 0) begin
                in_ch.valid <= 1'b0;
                tx_wait--;
            end else if (samples_to_send.size() != 0) begin
                on_wire = samples_to_send.pop_front();
                in_ch.valid  <= 1'b1;
                in_ch.action <= on_wire.action;
                in_ch.axis_x <= on_wire.axis_x;
                in_ch.axis_y <= on_wire.axis_y;
                in_ch.axis_z <= on_wire.axis_z;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result transaction: magnitude %0d", out_ch.magnitude);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("magnitude", want.magnitude, out_ch.magnitude);
                    check_field("deviation", want.deviation, out_ch.deviation);
                    check_field("axis_saturated", want.axis_saturated, out_ch.axis_saturated);
                    check_field("last_of_frame", want.last_of_frame, out_ch.last_of_frame);
                    check_field("frame_valid", want.frame_valid, out_ch.frame_valid);
                    check_field("source_present", want.source_present, out_ch.source_present);
                end
                rx_wait = rx_gaps_on ? $urandom_range(0, 12) : 0;
            end
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                rx_wait   = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                out_ch.ready <= 1'b0;
                rx_wait--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        int                    p;
        int                    k;
        int                    start;
        int                    stop;
        int                    pushed;
        int unsigned           eff;
        logic [COUNT_W-1:0]    n_cfg;
        logic [SPEED_W-1:0]    s_cfg;
        logic [THR_W-1:0]      t_cfg;
        logic [CFG_DATA_W-1:0] upper;

        i_rst_n       = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        in_ch.valid   = 1'b0;
        in_ch.action  = ACT_MEASURE;
        in_ch.axis_x  = '0;
        in_ch.axis_y  = '0;
        in_ch.axis_z  = '0;
        out_ch.ready  = 1'b0;
        for (k = 0; k < DEF_MAX_SENSORS; k++) begin
            nom_x[k] = int'($urandom_range(0, 6000)) - 3000;
            nom_y[k] = int'($urandom_range(0, 6000)) - 3000;
            nom_z[k] = int'($urandom_range(0, 6000)) - 3000;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero field, saturated frame, committed calibration, exact match
        push_sample(ACT_MEASURE, 0, 0, 0);
        push_sample(ACT_MEASURE, 4095, 4095, 4095);
        push_sample(ACT_MEASURE, -4096, -4096, -4096);
        push_sample(ACT_CALIB, 4090, -4090, 4090);
        push_sample(ACT_CALIB, -4090, 4090, -4090);
        push_sample(ACT_CALIB, 1, 2, 3);
        push_sample(ACT_MEASURE, 4090, -4090, 4090);
        push_sample(ACT_MEASURE, -4090, 4090, -4090);
        push_sample(ACT_MEASURE, 1, 2, 3);
        // calibration discarded by saturation
        push_sample(ACT_CALIB, 100, 200, 300);
        push_sample(ACT_CALIB, 4091, 0, 0);
        push_sample(ACT_CALIB, 7, 7, 7);
        // mixed frames: calibration last commits, measure last does not
        push_sample(ACT_CALIB, -1, -1, -1);
        push_sample(ACT_MEASURE, 1000, 0, 0);
        push_sample(ACT_CALIB, 0, 0, -4090);
        push_sample(ACT_CALIB, 5, 5, 5);
        push_sample(ACT_CALIB, 6, 6, 6);
        push_sample(ACT_MEASURE, -4090, -4090, -4090);
        push_sample(ACT_MEASURE, -1, -4096, 4095);
        push_sample(ACT_MEASURE, -4091, -4090, 4090);
        push_sample(ACT_MEASURE, 4090, 4091, -4095);
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin n_cfg = 3;  s_cfg = ONE_SPEED; t_cfg = 0;      end
                1: begin n_cfg = 8;  s_cfg = 1;         t_cfg = 131071; end
                2: begin n_cfg = 0;  s_cfg = 0;         t_cfg = 800;    end
                3: begin
                    n_cfg = 15;
                    s_cfg = 131071;
                    t_cfg = $urandom_range(0, 2000);
                end
                4: begin
                    n_cfg = 5;
                    s_cfg = 65537;
                    t_cfg = $urandom_range(0, 131071);
                end
                5: begin n_cfg = 2;  s_cfg = 32768;     t_cfg = 16;     end
                6: begin
                    n_cfg = 9;
                    s_cfg = $urandom_range(1, 65536);
                    t_cfg = 1600;
                end
                default: begin
                    n_cfg = $urandom_range(0, 15);
                    s_cfg = $urandom_range(0, 131071);
                    t_cfg = $urandom_range(0, 400);
                end
            endcase
            upper = (p % 2) ? (CFG_DATA_W'($urandom) & 17'h1FFF0) : '0;
            cfg_write(CFG_SENSOR_COUNT, upper | CFG_DATA_W'(n_cfg));
            cfg_write(CFG_EMA_SPEED, s_cfg);
            cfg_write(CFG_THRESHOLD, t_cfg);
            if (p == 3) cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));

            @(posedge i_clk);
            tx_gaps_on <= (p % 3 != 1) && p != 2 && p != 5;
            rx_gaps_on <= (p % 4 != 1);
            if (p == 2 || p == 5) hold_reqs <= hold_reqs + 1;

            // finish any frame left open by the previous phase, then whole frames
            eff    = frame_len();
            start  = frame_pos;
            pushed = 0;
            while (pushed < PHASE_ITEMS) begin
                stop = (start >= eff) ? start + 1 : eff;
                add_random_frame(start, stop);
                pushed += stop - start;
                start = 0;
            end
            if (p != PHASES - 1) add_random_frame(0, $urandom_range(1, eff - 1));
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/mbt_pkg.sv
src/mbt_channels.sv
src/mbt_front.sv
src/mbt_queue.sv
src/mbt_sqrt.sv
src/mbt_back.sv
src/magnetometer_baseline_tracker_top.sv
src/mbt_checker.sv
tb/tb_top.sv
